>>> src/sxz_pkg.sv
// Shared widths, pipeline depths and the sideband type for the segment crossing block.
package sxz_pkg;

  localparam int unsigned COORD_W  = 32;              // input coordinate width
  localparam int unsigned DIFF_W   = COORD_W + 1;     // exact coordinate difference
  localparam int unsigned PROD_W   = 2 * DIFF_W;      // product of two differences
  localparam int unsigned WIDE_W   = PROD_W + 1;      // sum of two products
  localparam int unsigned QUOT_W   = DIFF_W;          // quotient never exceeds |B1 - B0|
  localparam int unsigned NUM_W    = WIDE_W + QUOT_W; // dividend width
  localparam int unsigned PLO_W    = WIDE_W - DIFF_W; // low slice of the projection
  localparam int unsigned DIV_LAT  = QUOT_W + 2;      // load, one stage per bit, round
  localparam int unsigned PIPE_LEN = 5 + DIV_LAT + 2; // front stages, divider, tail

  // Per-request data that rides alongside the arithmetic.
  typedef struct packed {
    logic                       ok;
    logic signed [COORD_W-1:0]  bx0;
    logic signed [COORD_W-1:0]  bz0;
    logic                       negx;
    logic                       negz;
    logic [DIFF_W-1:0]          dmagx;
    logic [DIFF_W-1:0]          dmagz;
    logic signed [COORD_W-1:0]  ax_lo;
    logic signed [COORD_W-1:0]  ax_hi;
    logic signed [COORD_W-1:0]  az_lo;
    logic signed [COORD_W-1:0]  az_hi;
  } side_t;

endpackage

>>> src/sxz_div.sv
// Pipelined restoring divider with round-half-up, one quotient bit per stage.
module sxz_div
  import sxz_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [WIDE_W-1:0] den_i,
  output logic [QUOT_W-1:0] quot_o
);

  logic [WIDE_W-1:0] rem_q [0:QUOT_W];
  logic [QUOT_W-1:0] sh_q  [0:QUOT_W];
  logic [QUOT_W-1:0] q_q   [0:QUOT_W];
  logic [WIDE_W-1:0] den_q [0:QUOT_W];
  logic [QUOT_W-1:0] quot_q;
  logic [WIDE_W:0]   rnd_rem;
  logic              rnd_up;

  // Load: the upper dividend bits are already below the divisor.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[NUM_W-1:QUOT_W];
      sh_q[0]  <= num_i[QUOT_W-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
    end
  end

  // One compare and subtract per stage.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [WIDE_W:0]   r2;
    logic              ge;
    logic [WIDE_W-1:0] nrem;
    logic [WIDE_W:0]   dif;

    always_comb begin
      r2   = {rem_q[k], sh_q[k][QUOT_W-1]};
      dif  = r2 - {1'b0, den_q[k]};
      ge   = (r2 >= {1'b0, den_q[k]});
      nrem = ge ? dif[WIDE_W-1:0] : r2[WIDE_W-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= nrem;
        sh_q[k+1]  <= {sh_q[k][QUOT_W-2:0], 1'b0};
        q_q[k+1]   <= {q_q[k][QUOT_W-2:0], ge};
        den_q[k+1] <= den_q[k];
      end
    end
  end

  // Round to nearest, halves up on the magnitude.
  assign rnd_rem = {rem_q[QUOT_W], 1'b0};
  assign rnd_up  = (rnd_rem >= {1'b0, den_q[QUOT_W]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= q_q[QUOT_W] + QUOT_W'(rnd_up);
    end
  end

  assign quot_o = quot_q;

endmodule

>>> src/segment_intersection_xz.sv
// Top level of the x-z segment crossing pipeline.
//
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_ready_o   a_start_x_i .. b_stop_z_i (8 x 32-bit signed)
//  out      out_valid_o / out_ready_i hit_o, cross_x_o, cross_z_o
//
// A request can enter every cycle while the output is not stalled; out_valid_o rises
// once it has passed the front stages, the divider and the tail, and it leaves when taken.
// The depth is set by the divider, which resolves one quotient bit per stage.
// Reset clears only the valid bits; the data registers hold whatever they hold.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module segment_intersection_xz
  import sxz_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] a_start_x_i,
  input  logic signed [COORD_W-1:0] a_start_z_i,
  input  logic signed [COORD_W-1:0] a_stop_x_i,
  input  logic signed [COORD_W-1:0] a_stop_z_i,
  input  logic signed [COORD_W-1:0] b_start_x_i,
  input  logic signed [COORD_W-1:0] b_start_z_i,
  input  logic signed [COORD_W-1:0] b_stop_x_i,
  input  logic signed [COORD_W-1:0] b_stop_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic signed [COORD_W-1:0] cross_x_o,
  output logic signed [COORD_W-1:0] cross_z_o
);

  logic                en;
  logic [PIPE_LEN-1:0] vld_q, vld_d;

  // Stage 1 signals.
  logic signed [DIFF_W-1:0] dx_d, dz_d, ex_d, ez_d, fx_d, fz_d, delx_d, delz_d;
  logic signed [DIFF_W-1:0] dx_q, ndz_q, ex_q, ez_q, fx_q, fz_q;
  side_t                    side1_d, side1_q;

  // Stage 2..5 signals.
  logic signed [PROD_W-1:0] pa_q, pb_q, pc_q, pd_q;
  side_t                    side2_q, side3_q, side4_d, side4_q, side5_q;
  logic signed [WIDE_W-1:0] p0_q, d_q;
  logic [WIDE_W-1:0]        pm_d, dm_d, pm_q, dm_q, dm5_q;
  logic                     ok4;
  logic [WIDE_W-1:0]        pplx_q, pplz_q;
  logic [PROD_W-1:0]        pphx_q, pphz_q;
  logic [NUM_W-1:0]         numx, numz;

  // Divider and tail.
  side_t                    side_dly_q [0:DIV_LAT-1];
  logic [QUOT_W-1:0]        qx, qz;
  logic signed [DIFF_W:0]   cx_d, cz_d, cx_q, cz_q;
  side_t                    sidec_q;
  logic                     hit_d;
  logic                     hit_q;
  logic signed [COORD_W-1:0] crx_q, crz_q;

  // Global advance: everything moves unless the output holds a result not yet taken.
  assign en         = out_ready_i || !vld_q[PIPE_LEN-1];
  assign in_ready_o = en;
  assign vld_d      = {vld_q[PIPE_LEN-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: exact differences, box limits and B's direction.
  always_comb begin
    dx_d   = DIFF_W'(a_stop_x_i)  - DIFF_W'(a_start_x_i);
    dz_d   = DIFF_W'(a_stop_z_i)  - DIFF_W'(a_start_z_i);
    ex_d   = DIFF_W'(b_start_x_i) - DIFF_W'(a_start_x_i);
    ez_d   = DIFF_W'(b_start_z_i) - DIFF_W'(a_start_z_i);
    fx_d   = DIFF_W'(b_start_x_i) - DIFF_W'(b_stop_x_i);
    fz_d   = DIFF_W'(b_start_z_i) - DIFF_W'(b_stop_z_i);
    delx_d = DIFF_W'(b_stop_x_i)  - DIFF_W'(b_start_x_i);
    delz_d = DIFF_W'(b_stop_z_i)  - DIFF_W'(b_start_z_i);
    side1_d.ok    = 1'b0;
    side1_d.bx0   = b_start_x_i;
    side1_d.bz0   = b_start_z_i;
    side1_d.negx  = delx_d[DIFF_W-1];
    side1_d.negz  = delz_d[DIFF_W-1];
    side1_d.dmagx = delx_d[DIFF_W-1] ? DIFF_W'(-delx_d) : DIFF_W'(delx_d);
    side1_d.dmagz = delz_d[DIFF_W-1] ? DIFF_W'(-delz_d) : DIFF_W'(delz_d);
    side1_d.ax_lo = (a_start_x_i < a_stop_x_i) ? a_start_x_i : a_stop_x_i;
    side1_d.ax_hi = (a_start_x_i < a_stop_x_i) ? a_stop_x_i : a_start_x_i;
    side1_d.az_lo = (a_start_z_i < a_stop_z_i) ? a_start_z_i : a_stop_z_i;
    side1_d.az_hi = (a_start_z_i < a_stop_z_i) ? a_stop_z_i : a_start_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= dx_d;
      ndz_q   <= -dz_d;
      ex_q    <= ex_d;
      ez_q    <= ez_d;
      fx_q    <= fx_d;
      fz_q    <= fz_d;
      side1_q <= side1_d;
    end
  end

  // Stage 2: the four signed projection products.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q    <= PROD_W'(ex_q) * PROD_W'(ndz_q);
      pb_q    <= PROD_W'(ez_q) * PROD_W'(dx_q);
      pc_q    <= PROD_W'(fx_q) * PROD_W'(ndz_q);
      pd_q    <= PROD_W'(fz_q) * PROD_W'(dx_q);
      side2_q <= side1_q;
    end
  end

  // Stage 3: projection p0 and divisor d.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q    <= WIDE_W'(pa_q) + WIDE_W'(pb_q);
      d_q     <= WIDE_W'(pc_q) + WIDE_W'(pd_q);
      side3_q <= side2_q;
    end
  end

  // Stage 4: magnitudes and the test that t lies in the closed unit interval.
  always_comb begin
    pm_d = p0_q[WIDE_W-1] ? WIDE_W'(-p0_q) : WIDE_W'(p0_q);
    dm_d = d_q[WIDE_W-1]  ? WIDE_W'(-d_q)  : WIDE_W'(d_q);
    ok4  = (d_q != '0) && ((p0_q == '0) || (p0_q[WIDE_W-1] == d_q[WIDE_W-1]))
           && (pm_d <= dm_d);
    side4_d    = side3_q;
    side4_d.ok = ok4;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm_q    <= pm_d;
      dm_q    <= dm_d;
      side4_q <= side4_d;
    end
  end

  // Stage 5: partial products of |p0| and |B1 - B0| for each axis.
  always_ff @(posedge clk_i) begin
    if (en) begin
      pplx_q  <= WIDE_W'(pm_q[PLO_W-1:0]) * WIDE_W'(side4_q.dmagx);
      pphx_q  <= PROD_W'(pm_q[WIDE_W-1:PLO_W]) * PROD_W'(side4_q.dmagx);
      pplz_q  <= WIDE_W'(pm_q[PLO_W-1:0]) * WIDE_W'(side4_q.dmagz);
      pphz_q  <= PROD_W'(pm_q[WIDE_W-1:PLO_W]) * PROD_W'(side4_q.dmagz);
      dm5_q   <= dm_q;
      side5_q <= side4_q;
    end
  end

  // Dividend assembly feeds the divider load stage.
  assign numx = {{(NUM_W-WIDE_W){1'b0}}, pplx_q} + {pphx_q, {PLO_W{1'b0}}};
  assign numz = {{(NUM_W-WIDE_W){1'b0}}, pplz_q} + {pphz_q, {PLO_W{1'b0}}};

  sxz_div u_div_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numx),
    .den_i  (dm5_q),
    .quot_o (qx)
  );

  sxz_div u_div_z (
    .clk_i  (clk_i),
    .en_i   (en),
    .num_i  (numz),
    .den_i  (dm5_q),
    .quot_o (qz)
  );

  // Sideband delay line matching the divider latency.
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_dly_q[0] <= side5_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        side_dly_q[k] <= side_dly_q[k-1];
      end
    end
  end

  // Crossing point: B0 moved by the rounded offset toward B1.
  always_comb begin
    cx_d = side_dly_q[DIV_LAT-1].negx
         ? (DIFF_W+1)'(side_dly_q[DIV_LAT-1].bx0) - (DIFF_W+1)'({1'b0, qx})
         : (DIFF_W+1)'(side_dly_q[DIV_LAT-1].bx0) + (DIFF_W+1)'({1'b0, qx});
    cz_d = side_dly_q[DIV_LAT-1].negz
         ? (DIFF_W+1)'(side_dly_q[DIV_LAT-1].bz0) - (DIFF_W+1)'({1'b0, qz})
         : (DIFF_W+1)'(side_dly_q[DIV_LAT-1].bz0) + (DIFF_W+1)'({1'b0, qz});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q    <= cx_d;
      cz_q    <= cz_d;
      sidec_q <= side_dly_q[DIV_LAT-1];
    end
  end

  // Output stage: bounding box test of segment A, edges inclusive.
  assign hit_d = sidec_q.ok
              && (cx_q >= (DIFF_W+1)'(sidec_q.ax_lo)) && (cx_q <= (DIFF_W+1)'(sidec_q.ax_hi))
              && (cz_q >= (DIFF_W+1)'(sidec_q.az_lo)) && (cz_q <= (DIFF_W+1)'(sidec_q.az_hi));

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
      crx_q <= hit_d ? cx_q[COORD_W-1:0] : '0;
      crz_q <= hit_d ? cz_q[COORD_W-1:0] : '0;
    end
  end

  assign out_valid_o = vld_q[PIPE_LEN-1];
  assign hit_o       = hit_q;
  assign cross_x_o   = crx_q;
  assign cross_z_o   = crz_q;

`ifndef ASSERT_OFF
  // A miss always reports a zero point.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (cross_x_o == '0 && cross_z_o == '0))
    else $error("miss with nonzero crossing point");

  // The rounded offset never passes the far end of B.
  a_quot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[4+DIV_LAT] && side_dly_q[DIV_LAT-1].ok) |->
      (qx <= side_dly_q[DIV_LAT-1].dmagx && qz <= side_dly_q[DIV_LAT-1].dmagz))
    else $error("divider quotient exceeds segment length");

  // A held pipeline keeps its valid bits in place.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during a stall");
`endif

endmodule

>>> sim/sxz_checker.sv
// Checker for the segment crossing block: predicts every request and compares each result.
`timescale 1ns / 100ps

module sxz_checker
  import sxz_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [COORD_W-1:0] a_start_x_i,
  input  logic signed [COORD_W-1:0] a_start_z_i,
  input  logic signed [COORD_W-1:0] a_stop_x_i,
  input  logic signed [COORD_W-1:0] a_stop_z_i,
  input  logic signed [COORD_W-1:0] b_start_x_i,
  input  logic signed [COORD_W-1:0] b_start_z_i,
  input  logic signed [COORD_W-1:0] b_stop_x_i,
  input  logic signed [COORD_W-1:0] b_stop_z_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic                      hit_i,
  input  logic signed [COORD_W-1:0] cross_x_i,
  input  logic signed [COORD_W-1:0] cross_z_i,
  output int                        err_cnt_o,
  output int                        pending_o,
  output int                        hit_cnt_o
);

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cz;
  } crossing_t;

  crossing_t crossing_q[$];

  // Moves b0 toward b1 by |p| / |d| of the way, rounded half away from zero.
  function automatic longint walk_along(input longint b0, input longint b1,
                                        input logic [127:0] pm, input logic [127:0] dm);
    longint          delta;
    logic [127:0]    dmag;
    logic [127:0]    quo;
    logic [127:0]    rem;
    delta = b1 - b0;
    dmag  = (delta < 0) ? 128'(-delta) : 128'(delta);
    quo   = (pm * dmag) / dm;
    rem   = (pm * dmag) % dm;
    if ((rem << 1) >= dm) quo = quo + 1;
    return (delta < 0) ? b0 - longint'(quo) : b0 + longint'(quo);
  endfunction

  // Exact crossing test of B against A, with the box check on A.
  function automatic crossing_t predict_crossing(
    input logic signed [31:0] ax0_i, az0_i, ax1_i, az1_i,
    input logic signed [31:0] bx0_i, bz0_i, bx1_i, bz1_i);
    longint                ax0, az0, ax1, az1, bx0, bz0, bx1, bz1, dx, dz, cx, cz;
    logic signed [127:0]   p0, dd;
    logic [127:0]          pm, dm;
    logic                  ok;
    crossing_t             res;
    ax0 = ax0_i; az0 = az0_i; ax1 = ax1_i; az1 = az1_i;
    bx0 = bx0_i; bz0 = bz0_i; bx1 = bx1_i; bz1 = bz1_i;
    dx  = ax1 - ax0;
    dz  = az1 - az0;
    p0  = 128'(bx0 - ax0) * 128'(-dz) + 128'(bz0 - az0) * 128'(dx);
    dd  = 128'(bx0 - bx1) * 128'(-dz) + 128'(bz0 - bz1) * 128'(dx);
    pm  = (p0 < 0) ? -p0 : p0;
    dm  = (dd < 0) ? -dd : dd;
    res = '0;
    ok  = (dd != 0);
    if (ok && p0 != 0 && ((p0 < 0) != (dd < 0))) ok = 1'b0;
    if (ok && pm > dm) ok = 1'b0;
    if (ok) begin
      cx = walk_along(bx0, bx1, pm, dm);
      cz = walk_along(bz0, bz1, pm, dm);
      if (cx >= ((ax0 < ax1) ? ax0 : ax1) && cx <= ((ax0 < ax1) ? ax1 : ax0) &&
          cz >= ((az0 < az1) ? az0 : az1) && cz <= ((az0 < az1) ? az1 : az0)) begin
        res.hit = 1'b1;
        res.cx  = cx[31:0];
        res.cz  = cz[31:0];
      end
    end
    return res;
  endfunction

  assign pending_o = crossing_q.size();

  // Predict on each accepted request, compare on each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t exp_r;
    if (!rst_ni) begin
      err_cnt_o <= 0;
      hit_cnt_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        crossing_q.push_back(predict_crossing(a_start_x_i, a_start_z_i, a_stop_x_i,
                                              a_stop_z_i, b_start_x_i, b_start_z_i,
                                              b_stop_x_i, b_stop_z_i));
      if (out_valid_i && out_ready_i) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: result with no request pending: hit %0b x %0d z %0d",
                   $time, hit_i, cross_x_i, cross_z_i);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_r = crossing_q.pop_front();
          if (exp_r.hit) hit_cnt_o <= hit_cnt_o + 1;
          if (hit_i !== exp_r.hit || cross_x_i !== exp_r.cx || cross_z_i !== exp_r.cz) begin
            $display("%0t: mismatch: expected hit %0b x %0d z %0d, actual hit %0b x %0d z %0d",
                     $time, exp_r.hit, exp_r.cx, exp_r.cz, hit_i, cross_x_i, cross_z_i);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_segment_intersection_xz.sv
// Testbench top for the segment crossing block: stimulus, output pacing and verdict.
`timescale 1ns / 100ps

module tb_segment_intersection_xz;
  import sxz_pkg::*;

  localparam int unsigned NUM_RANDOM = 430;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned DRAIN_LEN  = PIPE_LEN + 20;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [COORD_W-1:0] ax0, az0, ax1, az1, bx0, bz0, bx1, bz1;
  logic                      out_valid;
  logic                      out_ready;
  logic                      hit;
  logic signed [COORD_W-1:0] cross_x, cross_z;
  logic                      in_ready_q;
  logic                      quiet;
  logic                      hold_req;
  logic                      hold_done;
  int                        err_cnt, pending, hit_cnt, stall_cnt, sent_cnt;

  segment_intersection_xz dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .a_start_x_i(ax0), .a_start_z_i(az0), .a_stop_x_i(ax1), .a_stop_z_i(az1),
    .b_start_x_i(bx0), .b_start_z_i(bz0), .b_stop_x_i(bx1), .b_stop_z_i(bz1),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_o(hit), .cross_x_o(cross_x), .cross_z_o(cross_z)
  );

  sxz_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .a_start_x_i(ax0), .a_start_z_i(az0), .a_stop_x_i(ax1), .a_stop_z_i(az1),
    .b_start_x_i(bx0), .b_start_z_i(bz0), .b_stop_x_i(bx1), .b_stop_z_i(bz1),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .hit_i(hit), .cross_x_i(cross_x), .cross_z_i(cross_z),
    .err_cnt_o(err_cnt), .pending_o(pending), .hit_cnt_o(hit_cnt)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Ready is stable between the falling edge and the next rising edge.
  always @(negedge clk_i) in_ready_q = in_ready;

  // Watchdog on cycles in which no request or result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("Timeout after %0d idle cycles", stall_cnt);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 12);
      end
    end
  end

  // Offers one request and returns on the edge at which it is taken.
  task automatic send_request(input logic signed [31:0] a0x, a0z, a1x, a1z,
                              input logic signed [31:0] b0x, b0z, b1x, b1z);
    while (!quiet && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    ax0 <= a0x; az0 <= a0z; ax1 <= a1x; az1 <= a1z;
    bx0 <= b0x; bz0 <= b0z; bx1 <= b1x; bz1 <= b1z;
    @(posedge clk_i);
    while (!in_ready_q) @(posedge clk_i);
    sent_cnt++;
  endtask

  function automatic logic signed [31:0] rnd_span(input int unsigned bits);
    logic [31:0] v;
    v = $urandom();
    v = v & ((bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 1));
    return $signed(v) - $signed(32'd1 << (bits - 1));
  endfunction

  // Request stream: directed corners first, then mostly crossing pairs.
  initial begin
    logic signed [31:0] px, pz, ux, uz, vx, vz, mx, mn;
    int unsigned        k1, k2, k3, k4, kind, bits;
    rst_ni    = 1'b0;
    in_valid  <= 1'b0;
    ax0 <= '0; az0 <= '0; ax1 <= '0; az1 <= '0;
    bx0 <= '0; bz0 <= '0; bx1 <= '0; bz1 <= '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    sent_cnt  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    mx = 32'sh7FFF_FFFF;
    mn = 32'sh8000_0000;
    // Plain crossing at the origin, X shape.
    send_request(-32'sh10000, 0, 32'sh10000, 0, 0, -32'sh10000, 0, 32'sh10000);
    // Crossing at A's end point, on the box edge.
    send_request(0, 0, 32'sh20000, 0, 32'sh20000, -32'sh10000, 32'sh20000, 32'sh10000);
    // B starts on A's line: zero projection.
    send_request(0, 0, 32'sh40000, 0, 32'sh10000, 0, 32'sh10000, 32'sh30000);
    // B ends on A's line.
    send_request(0, 0, 32'sh40000, 0, 32'sh10000, 32'sh30000, 32'sh10000, 0);
    // Parallel segments.
    send_request(0, 0, 32'sh40000, 0, 0, 32'sh10000, 32'sh40000, 32'sh10000);
    // Collinear segments: zero divisor with zero projection.
    send_request(0, 0, 32'sh40000, 0, 32'sh10000, 0, 32'sh30000, 0);
    // Degenerate A, a single point.
    send_request(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 0, 0, 32'sh20000, 32'sh20000);
    // Degenerate B.
    send_request(0, 0, 32'sh40000, 0, 32'sh10000, 0, 32'sh10000, 0);
    // B stops short of A's line.
    send_request(0, 0, 32'sh40000, 0, 32'sh10000, 32'sh10000, 32'sh10000, 32'sh5000);
    // Line crossing beyond A's end: outside the box.
    send_request(0, 0, 32'sh10000, 0, 32'sh30000, -32'sh10000, 32'sh30000, 32'sh10000);
    // Rounding at an exact half unit.
    send_request(0, 0, 32'sh4, 0, 1, -1, 2, 1);
    send_request(0, 0, 32'sh4, 0, 2, 1, 1, -1);
    // Diagonal with inexact division.
    send_request(0, 0, 7, 3, 0, 3, 7, 0);
    // Coordinate extremes.
    send_request(mn, mn, mx, mx, mn, mx, mx, mn);
    send_request(mx, mx, mn, mn, mx, mn, mn, mx);
    send_request(mn, 0, mx, 0, 0, mn, 0, mx);
    send_request(mn, mn, mn, mx, mx, 0, mn, 0);
    send_request(mx, mx, mx, mx, mx, mx, mx, mx);
    send_request(mn, mn, mn, mn, mn, mn, mn, mn);
    send_request(-1, -1, 0, 0, -1, 0, 0, -1);
    send_request(mx, mn, mn, mx, mn, mn, mx, mx);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      quiet    = (n >= 200 && n < 280);
      hold_req = hold_req || (n == 100);
      kind     = $urandom_range(99);
      bits     = ($urandom_range(3) == 0) ? 32 : $urandom_range(28, 4);
      if (kind < 25) begin
        // Raw noise over the full field range.
        send_request($urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom());
      end else if (kind < 35) begin
        // Parallel or collinear B, shifted along or across A.
        ux = rnd_span(bits > 24 ? 24 : bits);
        uz = rnd_span(bits > 24 ? 24 : bits);
        px = rnd_span(28);
        pz = rnd_span(28);
        k1 = $urandom_range(3);
        vx = ($urandom_range(1) != 0) ? rnd_span(12) : 0;
        send_request(px, pz, px + ux, pz + uz, px + vx, pz - vx,
                     px + vx + ux * k1, pz - vx + uz * k1);
      end else begin
        // Segments through a common point, ends sometimes on the point.
        bits = (bits > 26) ? 26 : bits;
        px = rnd_span(29);
        pz = rnd_span(29);
        ux = rnd_span(bits);
        uz = rnd_span(bits);
        vx = rnd_span(bits);
        vz = rnd_span(bits);
        k1 = $urandom_range(4);
        k2 = $urandom_range(4);
        k3 = $urandom_range(4);
        k4 = $urandom_range(4);
        send_request(px - ux * k1, pz - uz * k1, px + ux * k2, pz + uz * k2,
                     px - vx * k3 + $urandom_range(2), pz - vz * k3,
                     px + vx * k4, pz + vz * k4 - $urandom_range(2));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_LEN) @(posedge clk_i);

    $display("Sent %0d segment pairs: corners, parallel and degenerate cases, noise.",
             sent_cnt);
    $display("%0d pairs crossed; one long output hold-off filled the pipeline.", hit_cnt);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/sxz_pkg.sv
src/sxz_div.sv
src/segment_intersection_xz.sv
sim/sxz_checker.sv
sim/tb_segment_intersection_xz.sv
